[hdl/assert_macros.svh]
// Assertion macros used by the checker of the trimmed mean filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tmwf_pkg.sv]
// Package with widths, codes and controller/datapath interface types of the filter.
package tmwf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int MEAN_W         = 20;
    localparam int AXES           = 3;
    localparam int LEN_W          = 6;
    localparam int LEN_MIN        = 3;
    localparam int LEN_RESET      = 20;
    localparam int WINDOW_MAX_DEF = 32;

    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = AXES * SAMPLE_W;
    localparam int M_TDATA_W  = 64;

    // Register index as seen on paddr[2].
    localparam logic REG_WINDOW_LEN = 1'b0;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_first;
        logic trim;
        logic div_load;
        logic div_step;
        logic out_load;
    } tmwf_cmd_t;

    typedef struct packed {
        logic div_done;
    } tmwf_stat_t;

endpackage

[hdl/tmwf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tmwf_ram #(
    parameter int WIDTH = tmwf_pkg::S_TDATA_W,
    parameter int DEPTH = tmwf_pkg::WINDOW_MAX_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tmwf_ctrl.sv]
// Controller: register port, window bookkeeping and the per-item sequencer.
module tmwf_ctrl #(
    parameter int WINDOW_MAX = tmwf_pkg::WINDOW_MAX_DEF,
    localparam int AW = $clog2(WINDOW_MAX),
    localparam int CW = $clog2(WINDOW_MAX + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmwf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tmwf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmwf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output tmwf_pkg::tmwf_cmd_t             cmd,
    input  tmwf_pkg::tmwf_stat_t            stat,
    output logic [AW-1:0]                   wr_addr,
    output logic [AW-1:0]                   rd_addr,
    output logic [CW-1:0]                   divisor
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_TRIM,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [CW-1:0] LEN_MIN_C = CW'(tmwf_pkg::LEN_MIN);
    localparam logic [CW-1:0] LEN_MAX_C = CW'(WINDOW_MAX);

    state_t                      state_reg, state_next;
    logic [tmwf_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [AW-1:0]               slot_reg, slot_next;
    logic                        full_reg, full_next;
    logic [AW-1:0]               rcnt_reg, rcnt_next;
    logic                        mvalid_reg, mvalid_next;

    logic [CW-1:0] n_eff;
    logic [CW-1:0] slot_use;
    logic [CW-1:0] slot_inc;
    logic          cfg_hit;
    logic          s_xfer;
    logic          out_free;

    // Window length clamped to the supported range.
    always_comb begin
        if (int'(len_reg) < tmwf_pkg::LEN_MIN) begin
            n_eff = LEN_MIN_C;
        end else if (int'(len_reg) > WINDOW_MAX) begin
            n_eff = LEN_MAX_C;
        end else begin
            n_eff = CW'(len_reg);
        end
    end

    assign slot_use = (CW'(slot_reg) >= n_eff) ? '0 : CW'(slot_reg);
    assign slot_inc = slot_use + CW'(1);

    assign pready   = 1'b1;
    assign cfg_hit  = psel && penable && pwrite && pready &&
                      (paddr[2] == tmwf_pkg::REG_WINDOW_LEN);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        slot_next   = slot_reg;
        full_next   = full_reg;
        rcnt_next   = rcnt_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    cmd.wr_en = 1'b1;
                    if (slot_inc >= n_eff) begin
                        slot_next  = '0;
                        full_next  = 1'b1;
                        rcnt_next  = '0;
                        state_next = ST_SCAN;
                    end else begin
                        slot_next = slot_inc[AW-1:0];
                        if (full_reg) begin
                            rcnt_next  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (rcnt_reg == '0);
                rcnt_next    = rcnt_reg + AW'(1);
                if (CW'(rcnt_reg) == (n_eff - CW'(1))) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_TRIM;
            end
            ST_TRIM: begin
                cmd.trim   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A length write restarts the window from empty.
        if (cfg_hit) begin
            len_next  = pwdata[tmwf_pkg::LEN_W-1:0];
            slot_next = '0;
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            len_reg    <= tmwf_pkg::LEN_W'(tmwf_pkg::LEN_RESET);
            slot_reg   <= '0;
            full_reg   <= 1'b0;
            rcnt_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            slot_reg   <= slot_next;
            full_reg   <= full_next;
            rcnt_reg   <= rcnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign prdata   = (paddr[2] == tmwf_pkg::REG_WINDOW_LEN) ?
                      tmwf_pkg::APB_DATA_W'(len_reg) : '0;
    assign m_tvalid = mvalid_reg;
    assign wr_addr  = slot_use[AW-1:0];
    assign rd_addr  = rcnt_reg;
    assign divisor  = n_eff - CW'(2);

endmodule

[hdl/tmwf_datapath.sv]
// Datapath: sample RAM, per-axis sum/min/max scan, bit-serial dividers and output register.
module tmwf_datapath #(
    parameter int WINDOW_MAX = tmwf_pkg::WINDOW_MAX_DEF,
    localparam int AW    = $clog2(WINDOW_MAX),
    localparam int CW    = $clog2(WINDOW_MAX + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tmwf_pkg::tmwf_cmd_t            cmd,
    output tmwf_pkg::tmwf_stat_t           stat,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [AW-1:0]                  rd_addr,
    input  logic [CW-1:0]                  divisor,
    input  logic [tmwf_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [tmwf_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int SW    = tmwf_pkg::SAMPLE_W;
    localparam int QW    = tmwf_pkg::MEAN_W;
    localparam int NAX   = tmwf_pkg::AXES;
    localparam int SUM_W = SW + 1 + $clog2(WINDOW_MAX);
    localparam int MAG_W = SUM_W + 4;
    localparam int DCW   = $clog2(QW + 1);
    localparam int PAD_W = tmwf_pkg::M_TDATA_W - NAX * QW;

    logic [tmwf_pkg::S_TDATA_W-1:0] rd_data;

    logic                    acc_vld_reg, acc_vld_next;
    logic                    first_reg, first_next;
    logic [DCW-1:0]          dcnt_reg, dcnt_next;

    logic signed [SUM_W-1:0] sum_reg  [NAX];
    logic signed [SUM_W-1:0] sum_next [NAX];
    logic signed [SW-1:0]    lo_reg   [NAX];
    logic signed [SW-1:0]    lo_next  [NAX];
    logic signed [SW-1:0]    hi_reg   [NAX];
    logic signed [SW-1:0]    hi_next  [NAX];
    logic signed [SUM_W-1:0] net_reg  [NAX];
    logic signed [SUM_W-1:0] net_next [NAX];
    logic                    neg_reg  [NAX];
    logic                    neg_next [NAX];
    logic [CW-1:0]           rem_reg  [NAX];
    logic [CW-1:0]           rem_next [NAX];
    logic [QW-1:0]           quo_reg  [NAX];
    logic [QW-1:0]           quo_next [NAX];
    logic [QW-1:0]           mean_reg [NAX];
    logic [QW-1:0]           mean_next[NAX];

    tmwf_ram #(
        .WIDTH (tmwf_pkg::S_TDATA_W),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (s_tdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign acc_vld_next = cmd.rd_en;
    assign first_next   = cmd.rd_first;

    always_comb begin
        dcnt_next = dcnt_reg;
        if (cmd.div_load) begin
            dcnt_next = '0;
        end else if (cmd.div_step) begin
            dcnt_next = dcnt_reg + DCW'(1);
        end
    end

    assign stat.div_done = (dcnt_reg == DCW'(QW));

    always_comb begin
        logic signed [SW-1:0]  v;
        logic [SUM_W-1:0]      mag;
        logic [MAG_W-1:0]      mag4;
        logic [MAG_W-1:0]      top;
        logic [CW:0]           trial;
        logic [CW:0]           diff;
        logic                  ge;
        for (int a = 0; a < NAX; a++) begin
            sum_next[a]  = sum_reg[a];
            lo_next[a]   = lo_reg[a];
            hi_next[a]   = hi_reg[a];
            net_next[a]  = net_reg[a];
            neg_next[a]  = neg_reg[a];
            rem_next[a]  = rem_reg[a];
            quo_next[a]  = quo_reg[a];
            mean_next[a] = mean_reg[a];

            v = signed'(rd_data[a*SW +: SW]);
            if (acc_vld_reg) begin
                if (first_reg) begin
                    sum_next[a] = SUM_W'(v);
                    lo_next[a]  = v;
                    hi_next[a]  = v;
                end else begin
                    sum_next[a] = sum_reg[a] + SUM_W'(v);
                    if (v < lo_reg[a]) begin
                        lo_next[a] = v;
                    end
                    if (v > hi_reg[a]) begin
                        hi_next[a] = v;
                    end
                end
            end

            if (cmd.trim) begin
                net_next[a] = sum_reg[a] - SUM_W'(lo_reg[a]) - SUM_W'(hi_reg[a]);
            end

            // Divide the magnitude; the quotient fits in QW bits, so the bits
            // above QW start out as a partial remainder below the divisor.
            mag  = net_reg[a][SUM_W-1] ? unsigned'(-net_reg[a]) : unsigned'(net_reg[a]);
            mag4 = {mag, 4'b0000};
            top  = mag4 >> QW;
            if (cmd.div_load) begin
                neg_next[a] = net_reg[a][SUM_W-1];
                rem_next[a] = top[CW-1:0];
                quo_next[a] = mag4[QW-1:0];
            end

            trial = {rem_reg[a], quo_reg[a][QW-1]};
            diff  = trial - {1'b0, divisor};
            ge    = (trial >= {1'b0, divisor});
            if (cmd.div_step) begin
                rem_next[a] = ge ? diff[CW-1:0] : trial[CW-1:0];
                quo_next[a] = {quo_reg[a][QW-2:0], ge};
            end

            if (cmd.out_load) begin
                mean_next[a] = neg_reg[a] ? (-quo_reg[a]) : quo_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg <= 1'b0;
            first_reg   <= 1'b0;
            dcnt_reg    <= '0;
        end else begin
            acc_vld_reg <= acc_vld_next;
            first_reg   <= first_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < NAX; a++) begin
            sum_reg[a]  <= sum_next[a];
            lo_reg[a]   <= lo_next[a];
            hi_reg[a]   <= hi_next[a];
            net_reg[a]  <= net_next[a];
            neg_reg[a]  <= neg_next[a];
            rem_reg[a]  <= rem_next[a];
            quo_reg[a]  <= quo_next[a];
            mean_reg[a] <= mean_next[a];
        end
    end

    assign m_tdata = {PAD_W'(0), mean_reg[2], mean_reg[1], mean_reg[0]};

endmodule

[hdl/trimmed_mean_window_filter.sv]
// Top level of the three-axis trimmed mean window filter.
//
//   Channel   Direction   Handshake                 Contents
//   s_*       in          s_tvalid / s_tready       one x, y, z sample set per transfer
//   m_*       out         m_tvalid / m_tready       one x, y, z trimmed mean per transfer
//   apb       in/out      psel, penable, pwrite     window_len register at address 0
//
// An item that does not complete the window leaves s_tready high. An item with a result
// keeps s_tready low after its transfer while the window is scanned, the last read is
// drained, the sums trimmed, the dividers run and the result output. Reset clears the
// write slot and the window-full flag and sets window_len to 20; the RAM is not cleared.
// A result waits in the output register while the next item is taken in; the sequencer
// stalls only if that register is still full then.
module trimmed_mean_window_filter #(
    parameter int WINDOW_MAX = tmwf_pkg::WINDOW_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Register port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmwf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tmwf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmwf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,

    // Sample input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_sample [15:0], y_sample [31:16], z_sample [47:32]
    input  logic [tmwf_pkg::S_TDATA_W-1:0]  s_tdata,

    // Mean output.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // x_mean [19:0], y_mean [39:20], z_mean [59:40], zero [63:60]
    output logic [tmwf_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);

    // Command and status between the sequencer and the datapath.
    tmwf_pkg::tmwf_cmd_t  cmd;
    tmwf_pkg::tmwf_stat_t stat;

    // The write slot, the scan address and the divisor (window length minus
    // two) are computed in the controller, which owns the window bookkeeping.
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] divisor;

    tmwf_ctrl #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .divisor  (divisor)
    );

    // The datapath writes the sample on the input transfer, scans the window
    // for sum, minimum and maximum, divides the trimmed sum of each axis in
    // parallel, and holds the finished means in the output register.
    tmwf_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .divisor (divisor),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

[hdl/tmwf_checker.sv]
// Port-level checker for the trimmed mean filter, bound to the top level.
`include "assert_macros.svh"

module tmwf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic                            pready,
    input logic [tmwf_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [tmwf_pkg::APB_DATA_W-1:0] pwdata,
    input logic [tmwf_pkg::APB_DATA_W-1:0] prdata,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tmwf_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A stalled result stays offered and unchanged.
    `TMWF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed or dropped while stalled")

    // A new result only appears right after the input was busy.
    `TMWF_ASSERT_NOW(a_out_after_work, aclk, aresetn, $rose(m_tvalid), $past(!s_tready), "result appeared without a computation")

    // A length write reads back on the following cycle.
    `TMWF_ASSERT_NEXT(a_len_readback, aclk, aresetn, psel && penable && pwrite && pready && (paddr[2] == tmwf_pkg::REG_WINDOW_LEN), (paddr[2] != tmwf_pkg::REG_WINDOW_LEN) || (prdata == tmwf_pkg::APB_DATA_W'($past(pwdata[tmwf_pkg::LEN_W-1:0]))), "window_len readback mismatch")

    // No result is offered right after reset.
    `TMWF_ASSERT_NOW(a_reset_empty, aclk, aresetn, $past(!aresetn), !m_tvalid, "result offered after reset")

endmodule

bind trimmed_mean_window_filter tmwf_checker u_tmwf_checker (.*);
